@@ rtl/core/csc_pkg.sv @@
// Shared types, codes and constants of the convergence stop checker.
`default_nettype none
package csc_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_MAG,
      ST_MUL,
      ST_SQFIN,
      ST_ACC,
      ST_DIV_MEAN,
      ST_DIV_MSQ,
      ST_VAR,
      ST_HALF,
      ST_FIN
   } state_type;

   // stop rule codes; the unused code acts as the generation limit rule
   localparam logic [1:0] MODE_SIMILARITY  = 2'd0;
   localparam logic [1:0] MODE_DOUBLEBOX   = 2'd1;
   localparam logic [1:0] MODE_GENERATIONS = 2'd2;

   // register indexes on the csr port
   localparam logic [1:0] REG_STOP_MODE   = 2'd0;
   localparam logic [1:0] REG_MAX_GEN     = 2'd1;
   localparam logic [1:0] REG_SIM_LIMIT   = 2'd2;

   localparam logic [1:0]  RST_STOP_MODE = MODE_DOUBLEBOX;
   localparam logic [15:0] RST_MAX_GEN   = 16'd100;
   localparam logic [15:0] RST_SIM_LIMIT = 16'd15;

   localparam logic signed [64:0] SIM_TOL     = 65'sd43;
   localparam logic signed [63:0] LEVEL_FLOOR = 64'sd42950;
   localparam logic signed [64:0] ONE_Q       = 65'sh1_0000_0000;
   localparam logic [63:0]        POS_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [31:0]        SQ_HI_LIMIT = 32'd46340;
   localparam logic [15:0]        MIN_GENS    = 16'd20;
   localparam logic [15:0]        CNT_MAX     = 16'hFFFF;

   // square takes three products plus one accumulate step
   localparam logic [3:0] MUL_LAST = 4'd3;
   // 64 quotient bits at four bits a cycle
   localparam logic [3:0] DIV_LAST = 4'd15;
   localparam int         DIV_BITS = 4;

   typedef struct packed {
      logic signed [63:0] previous_best;
      logic [15:0]        unchanged_count;
      logic [63:0]        value_sum;
      logic [63:0]        square_sum;
      logic signed [63:0] stop_level;
   } entry_type;

   // both operands are known to be below 2^63
   function automatic logic [63:0] sat_add_pos(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return s[63] ? POS_MAX : s;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/convergence_stop_checker.sv @@
// Per-cluster termination test: similarity, doublebox variance and generation limit rules.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_ready  | cluster_index, best_value, generation_count
//  rsp     | out | rsp_valid/rsp_ready  | stop
//  csr     | in  | APB psel/penable     | stop_mode, max_generations, similarity_limit
//
// Similarity and generation rules load the result in ST_READ once the output is free.
// Doublebox loads the result in ST_FIN, after two divisions by generation+1 in a radix-16
// divider and two squarings on one 32x32 multiplier, once the output is free.
// req_ready is high only in idle; a result waiting in the output register does not
// block a new beat, but the next result holds until that one is taken.
// reset is synchronous; it clears the per-cluster valid bits, so state reads as zero.
`default_nettype none
module convergence_stop_checker #(
   parameter int CLUSTERS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_cluster_index,
   input  wire logic signed [63:0] req_best_value,
   input  wire logic [15:0]        req_generation_count,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_stop,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [3:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   localparam int AW = $clog2(CLUSTERS);
   localparam int IW = (AW > 3) ? AW : 3;

   csc_pkg::state_type state_ff, state_in;

   logic [1:0]  stop_mode_ff;
   logic [15:0] max_gen_ff;
   logic [15:0] sim_limit_ff;

   csc_pkg::entry_type mem [CLUSTERS];
   logic [CLUSTERS-1:0] valid_ff;
   csc_pkg::entry_type  rd_ff;
   logic                rd_valid_ff;
   csc_pkg::entry_type  ent;
   csc_pkg::entry_type  wr_entry;
   logic                wr_en;

   logic [IW-1:0]      idx_ext;
   logic [AW-1:0]      req_addr;
   logic               req_accept;
   logic               out_free;
   logic               rsp_load;
   logic               rsp_stop_val;
   logic               cfg_we;

   logic [AW-1:0]      addr_ff, addr_in;
   logic               inrange_ff, inrange_in;
   logic signed [63:0] best_ff, best_in;
   logic [15:0]        gen_ff, gen_in;
   logic [63:0]        op_ff, op_in;
   logic [64:0]        acc_ff, acc_in;
   logic [63:0]        prod_ff, prod_in;
   logic [3:0]         step_ff, step_in;
   logic               pass_ff, pass_in;
   logic [63:0]        sq_ff, sq_in;
   logic [63:0]        vs_new_ff, vs_new_in;
   logic [63:0]        ss_new_ff, ss_new_in;
   logic [63:0]        mean_sq_ff, mean_sq_in;
   logic signed [63:0] var_ff, var_in;
   logic signed [63:0] half_ff, half_in;
   logic               lt_ff, lt_in;
   logic [63:0]        q_ff, q_in;
   logic [15:0]        rem_ff, rem_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_stop_ff, rsp_stop_in;

   logic signed [64:0] sim_diff;
   logic               sim_same;
   logic [15:0]        cnt_new;
   logic               sim_stop;
   logic               gen_stop;
   logic signed [64:0] shift_sum;
   logic [63:0]        shifted;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        product;
   logic [64:0]        acc_term;
   logic [63:0]        sq_sat;
   logic [16:0]        div_n;
   logic [63:0]        div_q_nx;
   logic [15:0]        div_rem_nx;
   logic signed [63:0] lvl0, lvl_new;
   logic               db_stop;

   assign idx_ext    = IW'(req_cluster_index);
   assign req_addr   = idx_ext[AW-1:0];
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign ent        = rd_valid_ff ? rd_ff : '0;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_stop   = rsp_stop_ff;
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_mode_ff <= csc_pkg::RST_STOP_MODE;
         max_gen_ff   <= csc_pkg::RST_MAX_GEN;
         sim_limit_ff <= csc_pkg::RST_SIM_LIMIT;
      end else if (cfg_we) begin
         case (csr_paddr[3:2])
            csc_pkg::REG_STOP_MODE: stop_mode_ff <= csr_pwdata[1:0];
            csc_pkg::REG_MAX_GEN:   max_gen_ff   <= csr_pwdata[15:0];
            csc_pkg::REG_SIM_LIMIT: sim_limit_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         csc_pkg::REG_STOP_MODE: csr_prdata = {30'd0, stop_mode_ff};
         csc_pkg::REG_MAX_GEN:   csr_prdata = {16'd0, max_gen_ff};
         csc_pkg::REG_SIM_LIMIT: csr_prdata = {16'd0, sim_limit_ff};
         default:                csr_prdata = 32'd0;
      endcase
   end

   // per-cluster state memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr_ff] <= wr_entry;
      end
      if (req_accept) begin
         rd_ff       <= mem[req_addr];
         rd_valid_ff <= valid_ff[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[addr_ff] <= 1'b1;
      end
   end

   // similarity and generation rules
   assign sim_diff = $signed({best_ff[63], best_ff}) -
                     $signed({ent.previous_best[63], ent.previous_best});
   assign sim_same = (sim_diff > -csc_pkg::SIM_TOL) && (sim_diff < csc_pkg::SIM_TOL);
   always_comb begin
      if (!sim_same) begin
         cnt_new = 16'd0;
      end else if (ent.unchanged_count < csc_pkg::CNT_MAX) begin
         cnt_new = ent.unchanged_count + 16'd1;
      end else begin
         cnt_new = ent.unchanged_count;
      end
   end
   assign sim_stop = cnt_new >= sim_limit_ff;
   assign gen_stop = gen_ff >= max_gen_ff;

   // 1+best, saturating on the positive side
   assign shift_sum = $signed({best_ff[63], best_ff}) + csc_pkg::ONE_Q;
   assign shifted   = (!shift_sum[64] && shift_sum[63]) ? csc_pkg::POS_MAX : shift_sum[63:0];

   // shared multiplier: hi*hi, hi*lo, lo*lo of op_ff
   always_comb begin
      case (step_ff)
         4'd0:    begin mul_a = op_ff[63:32]; mul_b = op_ff[63:32]; end
         4'd1:    begin mul_a = op_ff[63:32]; mul_b = op_ff[31:0];  end
         default: begin mul_a = op_ff[31:0];  mul_b = op_ff[31:0];  end
      endcase
   end
   assign product = mul_a * mul_b;

   always_comb begin
      case (step_ff)
         4'd1:    acc_term = 65'(prod_ff) << 32;
         4'd2:    acc_term = 65'(prod_ff) << 1;
         4'd3:    acc_term = 65'(prod_ff[63:32]);
         default: acc_term = 65'd0;
      endcase
   end
   assign sq_sat = ((op_ff[63:32] > csc_pkg::SQ_HI_LIMIT) || (acc_ff[64:63] != 2'b00)) ?
                   csc_pkg::POS_MAX : acc_ff[63:0];

   // four restoring divider steps a cycle
   assign div_n = {1'b0, gen_ff} + 17'd1;
   always_comb begin
      logic [63:0] q;
      logic [16:0] r;
      logic [15:0] rm;
      q  = q_ff;
      rm = rem_ff;
      for (int k = 0; k < csc_pkg::DIV_BITS; k++) begin
         r = {rm, q[63]};
         q = {q[62:0], 1'b0};
         if (r >= div_n) begin
            r    = r - div_n;
            q[0] = 1'b1;
         end
         rm = r[15:0];
      end
      div_q_nx   = q;
      div_rem_nx = rm;
   end

   // stop level and doublebox decision
   always_comb begin
      if (lt_ff || (gen_ff <= 16'd1)) begin
         lvl0 = half_ff;
      end else begin
         lvl0 = ent.stop_level;
      end
      lvl_new = (lvl0 < csc_pkg::LEVEL_FLOOR) ? half_ff : lvl0;
      db_stop = gen_stop || ((var_ff <= lvl_new) && (gen_ff >= csc_pkg::MIN_GENS));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csc_pkg::ST_IDLE: begin
            if (req_accept) state_in = csc_pkg::ST_READ;
         end
         csc_pkg::ST_READ: begin
            if (inrange_ff && (stop_mode_ff == csc_pkg::MODE_DOUBLEBOX)) begin
               state_in = csc_pkg::ST_MAG;
            end else if (out_free) begin
               state_in = csc_pkg::ST_IDLE;
            end
         end
         csc_pkg::ST_MAG: state_in = csc_pkg::ST_MUL;
         csc_pkg::ST_MUL: begin
            if (step_ff == csc_pkg::MUL_LAST) state_in = csc_pkg::ST_SQFIN;
         end
         csc_pkg::ST_SQFIN: state_in = pass_ff ? csc_pkg::ST_VAR : csc_pkg::ST_ACC;
         csc_pkg::ST_ACC: state_in = csc_pkg::ST_DIV_MEAN;
         csc_pkg::ST_DIV_MEAN: begin
            if (step_ff == csc_pkg::DIV_LAST) state_in = csc_pkg::ST_DIV_MSQ;
         end
         csc_pkg::ST_DIV_MSQ: begin
            if (step_ff == csc_pkg::DIV_LAST) state_in = csc_pkg::ST_MUL;
         end
         csc_pkg::ST_VAR:  state_in = csc_pkg::ST_HALF;
         csc_pkg::ST_HALF: state_in = csc_pkg::ST_FIN;
         csc_pkg::ST_FIN: begin
            if (out_free) state_in = csc_pkg::ST_IDLE;
         end
         default: state_in = csc_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      rsp_load     = 1'b0;
      rsp_stop_val = 1'b0;
      wr_entry     = ent;
      wr_entry.previous_best = best_ff;
      case (state_ff)
         csc_pkg::ST_IDLE: req_ready = 1'b1;
         csc_pkg::ST_READ: begin
            if (!inrange_ff) begin
               rsp_load = out_free;
            end else if (stop_mode_ff == csc_pkg::MODE_SIMILARITY) begin
               wr_en        = out_free;
               rsp_load     = out_free;
               rsp_stop_val = sim_stop;
               wr_entry.unchanged_count = cnt_new;
            end else if (stop_mode_ff != csc_pkg::MODE_DOUBLEBOX) begin
               wr_en        = out_free;
               rsp_load     = out_free;
               rsp_stop_val = gen_stop;
            end
         end
         csc_pkg::ST_FIN: begin
            wr_en                = out_free;
            rsp_load             = out_free;
            rsp_stop_val         = db_stop;
            wr_entry.value_sum   = vs_new_ff;
            wr_entry.square_sum  = ss_new_ff;
            wr_entry.stop_level  = lvl_new;
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      addr_in    = addr_ff;
      inrange_in = inrange_ff;
      best_in    = best_ff;
      gen_in     = gen_ff;
      op_in      = op_ff;
      acc_in     = acc_ff;
      prod_in    = prod_ff;
      step_in    = step_ff;
      pass_in    = pass_ff;
      sq_in      = sq_ff;
      vs_new_in  = vs_new_ff;
      ss_new_in  = ss_new_ff;
      mean_sq_in = mean_sq_ff;
      var_in     = var_ff;
      half_in    = half_ff;
      lt_in      = lt_ff;
      q_in       = q_ff;
      rem_in     = rem_ff;
      case (state_ff)
         csc_pkg::ST_IDLE: begin
            if (req_accept) begin
               addr_in    = req_addr;
               inrange_in = 32'(req_cluster_index) < CLUSTERS;
               best_in    = req_best_value;
               gen_in     = req_generation_count;
            end
         end
         csc_pkg::ST_READ: begin
            op_in = shifted;
            lt_in = best_ff < $signed(ent.previous_best);
         end
         csc_pkg::ST_MAG: begin
            op_in   = op_ff[63] ? 64'(-op_ff) : op_ff;
            acc_in  = 65'd0;
            step_in = 4'd0;
            pass_in = 1'b0;
         end
         csc_pkg::ST_MUL: begin
            prod_in = product;
            acc_in  = acc_ff + acc_term;
            step_in = step_ff + 4'd1;
         end
         csc_pkg::ST_SQFIN: sq_in = sq_sat;
         csc_pkg::ST_ACC: begin
            vs_new_in = csc_pkg::sat_add_pos(ent.value_sum, op_ff);
            ss_new_in = csc_pkg::sat_add_pos(ent.square_sum, sq_ff);
            q_in      = csc_pkg::sat_add_pos(ent.value_sum, op_ff);
            rem_in    = 16'd0;
            step_in   = 4'd0;
         end
         csc_pkg::ST_DIV_MEAN: begin
            q_in    = div_q_nx;
            rem_in  = div_rem_nx;
            step_in = step_ff + 4'd1;
            if (step_ff == csc_pkg::DIV_LAST) begin
               // mean goes to the multiplier operand; start on the square sum
               op_in   = div_q_nx;
               q_in    = ss_new_ff;
               rem_in  = 16'd0;
               step_in = 4'd0;
            end
         end
         csc_pkg::ST_DIV_MSQ: begin
            q_in    = div_q_nx;
            rem_in  = div_rem_nx;
            step_in = step_ff + 4'd1;
            if (step_ff == csc_pkg::DIV_LAST) begin
               mean_sq_in = div_q_nx;
               step_in    = 4'd0;
               acc_in     = 65'd0;
               pass_in    = 1'b1;
            end
         end
         csc_pkg::ST_VAR: var_in = $signed(mean_sq_ff) - $signed(sq_ff);
         csc_pkg::ST_HALF: begin
            // halve toward zero
            half_in = (var_ff >>> 1) + $signed({63'd0, var_ff[63] & var_ff[0]});
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign rsp_stop_in  = rsp_load ? rsp_stop_val : rsp_stop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_stop_ff <= rsp_stop_in;
      addr_ff     <= addr_in;
      inrange_ff  <= inrange_in;
      best_ff     <= best_in;
      gen_ff      <= gen_in;
      op_ff       <= op_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      step_ff     <= step_in;
      pass_ff     <= pass_in;
      sq_ff       <= sq_in;
      vs_new_ff   <= vs_new_in;
      ss_new_ff   <= ss_new_in;
      mean_sq_ff  <= mean_sq_in;
      var_ff      <= var_in;
      half_ff     <= half_in;
      lt_ff       <= lt_in;
      q_ff        <= q_in;
      rem_ff      <= rem_in;
   end

   a_no_oob_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> inrange_ff)
      else $error("state write for a cluster out of range");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == csc_pkg::ST_DIV_MEAN || state_ff == csc_pkg::ST_DIV_MSQ) |->
      ({1'b0, rem_ff} < div_n))
      else $error("divider remainder not below divisor");

   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == csc_pkg::ST_READ))
      else $error("accepted beat did not start a state read");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result loaded over a waiting beat");

endmodule
`default_nettype wire

@@ bench/tb_convergence_stop_checker.sv @@
// Self-checking bench for convergence_stop_checker: directed edges, output stalls, random runs.
module tb_convergence_stop_checker;

   localparam int NUM_CLUSTERS  = 8;
   localparam int ITEM_TARGET   = 1850;
   // worst quiet stretch: the HOLD_CYCLES output hold plus a long gap and a doublebox pass
   localparam int IDLE_LIMIT    = 3000;
   localparam int TAIL_CYCLES   = 60;
   localparam int SETTLE_CYCLES = 8;
   localparam int PRINT_CAP     = 40;
   localparam int HOLD_CYCLES   = 400;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic signed [63:0] Q_ONE     = 64'sh0000_0001_0000_0000;
   localparam logic signed [63:0] Q_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] Q_MIN     = 64'sh8000_0000_0000_0000;
   localparam logic [63:0]        FLAT_TOL  = 64'd43;      // 1e-8 in Q32.32
   localparam logic signed [63:0] LEVEL_MIN = 64'sd42950;  // 1e-5 in Q32.32
   localparam logic [15:0]        WARMUP_GENS = 16'd20;

   typedef struct packed {
      logic [2:0]  cluster;
      logic [15:0] gen;
      logic        stop;
   } stop_due_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_cluster_index = '0;
   logic signed [63:0] req_best_value = '0;
   logic [15:0]        req_generation_count = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_stop;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   // mirrored registers and per-cluster history
   logic [1:0]         mode_cfg = csc_pkg::RST_STOP_MODE;
   logic [15:0]        max_gen_cfg = csc_pkg::RST_MAX_GEN;
   logic [15:0]        sim_limit_cfg = csc_pkg::RST_SIM_LIMIT;
   logic signed [63:0] prior_best [NUM_CLUSTERS];
   logic [15:0]        flat_run [NUM_CLUSTERS];
   logic [63:0]        value_acc [NUM_CLUSTERS];
   logic [63:0]        square_acc [NUM_CLUSTERS];
   logic signed [63:0] level [NUM_CLUSTERS];

   // stimulus run state per cluster
   logic [15:0]        track_gen [NUM_CLUSTERS];
   logic signed [63:0] track_best [NUM_CLUSTERS];

   stop_due_type pending_stops[$];
   stop_due_type due_now;

   int  fail_count = 0;
   int  printed = 0;
   int  reports_sent = 0;
   int  results_seen = 0;
   int  stops_seen = 0;
   int  settings_used = 0;
   int  mode_reports [4] = '{0, 0, 0, 0};
   int  idle_cycles = 0;
   bit  sender_calm = 1'b0;
   bit  receiver_calm = 1'b0;
   int  hold_len = 0;
   int  hold_seq = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   int  stall_left = 0;

   convergence_stop_checker dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_cluster_index    (req_cluster_index),
      .req_best_value       (req_best_value),
      .req_generation_count (req_generation_count),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_stop             (rsp_stop),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Q32.32 square, floored, capped at the largest positive value
   function automatic logic [63:0] square_q(input logic [63:0] m);
      logic [127:0] full;
      full = ({64'd0, m} * {64'd0, m}) >> 32;
      return (full > {64'd0, Q_MAX}) ? Q_MAX : full[63:0];
   endfunction

   function automatic logic [63:0] add_capped(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, Q_MAX}) ? Q_MAX : s[63:0];
   endfunction

   function automatic logic predict_stop(input logic [2:0] c, input logic signed [63:0] best,
                                         input logic [15:0] gen);
      logic [63:0]        diff;
      logic [63:0]        mag;
      logic [63:0]        count;
      logic [63:0]        mean;
      logic [63:0]        mean_sq;
      logic signed [63:0] shifted;
      logic signed [63:0] spread;
      logic               stop;
      stop = 1'b0;
      case (mode_cfg)
         csc_pkg::MODE_SIMILARITY: begin
            diff = (prior_best[c] >= best) ? prior_best[c] - best : best - prior_best[c];
            if (diff < FLAT_TOL) begin
               if (flat_run[c] != 16'hFFFF) flat_run[c] = flat_run[c] + 16'd1;
            end else begin
               flat_run[c] = '0;
            end
            stop = flat_run[c] >= sim_limit_cfg;
         end
         csc_pkg::MODE_DOUBLEBOX: begin
            shifted = (best > Q_MAX - Q_ONE) ? Q_MAX : best + Q_ONE;
            mag = shifted[63] ? -shifted : shifted;
            value_acc[c] = add_capped(value_acc[c], mag);
            square_acc[c] = add_capped(square_acc[c], square_q(mag));
            count = {48'd0, gen} + 64'd1;
            mean = value_acc[c] / count;
            mean_sq = square_acc[c] / count;
            spread = mean_sq - square_q(mean);
            // re-arm the level on improvement, early generations or a vanishing level
            if (best < prior_best[c] || gen <= 16'd1) level[c] = spread / 64'sd2;
            if (level[c] < LEVEL_MIN) level[c] = spread / 64'sd2;
            stop = gen >= max_gen_cfg || (spread <= level[c] && gen >= WARMUP_GENS);
         end
         default: begin
            stop = gen >= max_gen_cfg;
         end
      endcase
      prior_best[c] = best;
      return stop;
   endfunction

   function automatic logic signed [63:0] fresh_value();
      logic [31:0] whole;
      whole = $urandom_range(0, 16) - 8;
      case ($urandom_range(0, 10))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return -Q_ONE;
         3: return Q_MAX - Q_ONE;
         4: return Q_MAX - Q_ONE + 64'sd1;
         5, 6, 7: return {$urandom(), $urandom()};
         default: return {whole, $urandom()};
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      if (printed < PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
      printed++;
      fail_count++;
   endtask

   task automatic read_reg_check(input logic [1:0] idx);
      logic [31:0] want;
      case (idx)
         csc_pkg::REG_STOP_MODE: want = {30'd0, mode_cfg};
         csc_pkg::REG_MAX_GEN:   want = {16'd0, max_gen_cfg};
         default:                want = {16'd0, sim_limit_cfg};
      endcase
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== want)
         report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                   idx, csr_prdata, want));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         csc_pkg::REG_STOP_MODE: mode_cfg = value[1:0];
         csc_pkg::REG_MAX_GEN:   max_gen_cfg = value[15:0];
         csc_pkg::REG_SIM_LIMIT: sim_limit_cfg = value[15:0];
         default: ;
      endcase
      read_reg_check(idx);
   endtask

   task automatic send_report(input logic [2:0] c, input logic signed [63:0] best,
                              input logic [15:0] gen);
      int           gap;
      stop_due_type due;
      gap = sender_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cluster_index <= c;
      req_best_value <= best;
      req_generation_count <= gen;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      due.cluster = c;
      due.gen = gen;
      due.stop = predict_stop(c, best, gen);
      pending_stops = {pending_stops, due};
      reports_sent++;
      mode_reports[mode_cfg]++;
   endtask

   // next generation of a cluster's run: mostly steady or slowly improving values
   task automatic send_next_generation(input logic [2:0] c, input int steady_pct);
      int                 r;
      logic [63:0]        nudge;
      logic signed [63:0] best;
      logic [15:0]        gen;
      best = track_best[c];
      if ($urandom_range(0, 99) >= steady_pct) begin
         r = $urandom_range(0, 99);
         nudge = 64'($urandom_range(0, 120));
         if (r < 40) best = best + nudge - 64'd60;
         else if (r < 75) best = best - {32'd0, $urandom()};
         else if (r < 92) best = {$urandom(), $urandom()};
         else best = fresh_value();
      end
      gen = track_gen[c];
      if ($urandom_range(0, 99) < 4) gen = 16'($urandom_range(0, 65535));
      track_gen[c] = track_gen[c] + 16'd1;
      track_best[c] = best;
      send_report(c, best, gen);
   endtask

   task automatic wait_results_done(input int extra);
      req_valid <= 1'b0;
      while (pending_stops.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic test_register_readback();
      read_reg_check(csc_pkg::REG_STOP_MODE);
      read_reg_check(csc_pkg::REG_MAX_GEN);
      read_reg_check(csc_pkg::REG_SIM_LIMIT);
   endtask

   task automatic test_doublebox_edges();
      send_report(3'd0, 64'sd0, 16'd0);
      send_report(3'd0, 64'sd0, 16'd1);
      send_report(3'd0, Q_MAX, 16'd2);      // shift saturates
      send_report(3'd0, Q_MIN, 16'd3);      // large magnitude, squares cap
      send_report(3'd1, -Q_ONE, 16'd0);     // magnitude zero
      send_report(3'd1, -Q_ONE, 16'd20);
      send_report(3'd2, Q_ONE, 16'd65535);
      send_report(3'd3, Q_ONE, 16'd99);
      send_report(3'd3, Q_ONE, 16'd100);
      wait_results_done(SETTLE_CYCLES);
   endtask

   task automatic test_similarity_edges();
      set_reg(csc_pkg::REG_STOP_MODE, 32'(csc_pkg::MODE_SIMILARITY));
      set_reg(csc_pkg::REG_SIM_LIMIT, 32'd2);
      send_report(3'd4, Q_ONE, 16'd0);
      send_report(3'd4, Q_ONE, 16'd1);
      send_report(3'd4, Q_ONE + 64'sd42, 16'd2);   // just inside tolerance
      send_report(3'd4, Q_ONE + 64'sd85, 16'd3);   // exactly at tolerance: run breaks
      send_report(3'd5, Q_MAX, 16'd0);
      send_report(3'd5, Q_MIN, 16'd1);             // full-range difference
      wait_results_done(SETTLE_CYCLES);
      set_reg(csc_pkg::REG_SIM_LIMIT, 32'd0);
      send_report(3'd6, Q_MIN, 16'd7);
      wait_results_done(SETTLE_CYCLES);
      set_reg(csc_pkg::REG_SIM_LIMIT, 32'hFFFF);
      send_report(3'd6, Q_MIN, 16'd8);
      wait_results_done(SETTLE_CYCLES);
   endtask

   task automatic test_generation_limit();
      set_reg(csc_pkg::REG_STOP_MODE, 32'(csc_pkg::MODE_GENERATIONS));
      set_reg(csc_pkg::REG_MAX_GEN, 32'd0);
      send_report(3'd7, 64'sd0, 16'd0);
      wait_results_done(SETTLE_CYCLES);
      set_reg(csc_pkg::REG_STOP_MODE, 32'(MODE_UNUSED));
      set_reg(csc_pkg::REG_MAX_GEN, 32'hFFFF);
      send_report(3'd7, Q_MAX, 16'd65534);
      send_report(3'd7, Q_MIN, 16'd65535);
      wait_results_done(SETTLE_CYCLES);
   endtask

   task automatic test_output_backpressure();
      int i;
      set_reg(csc_pkg::REG_STOP_MODE, 32'(csc_pkg::MODE_DOUBLEBOX));
      set_reg(csc_pkg::REG_MAX_GEN, 32'd40);
      sender_calm = 1'b1;
      hold_len <= HOLD_CYCLES;
      hold_seq <= hold_seq + 1;
      for (i = 0; i < 12; i++) send_next_generation(3'(i % NUM_CLUSTERS), 80);
      // hold the sender until every flag is back, then resume
      wait_results_done(0);
      for (i = 0; i < 6; i++) send_next_generation(3'(i % NUM_CLUSTERS), 80);
      sender_calm = 1'b0;
      wait_results_done(SETTLE_CYCLES);
   endtask

   task automatic test_random_campaign();
      int         r;
      int         k;
      int         span;
      int         steady_pct;
      int         phase_items;
      logic [1:0] mode;
      while (reports_sent < ITEM_TARGET) begin
         wait_results_done(SETTLE_CYCLES);
         r = $urandom_range(0, 19);
         if (r < 9) mode = csc_pkg::MODE_DOUBLEBOX;
         else if (r < 15) mode = csc_pkg::MODE_SIMILARITY;
         else if (r < 18) mode = csc_pkg::MODE_GENERATIONS;
         else mode = MODE_UNUSED;
         set_reg(csc_pkg::REG_STOP_MODE, {30'd0, mode});
         if ($urandom_range(0, 1) == 0) begin
            r = $urandom_range(0, 9);
            set_reg(csc_pkg::REG_MAX_GEN,
                    (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF :
                    (r == 2) ? $urandom_range(0, 65535) : $urandom_range(10, 80));
         end
         if ($urandom_range(0, 1) == 0) begin
            r = $urandom_range(0, 9);
            set_reg(csc_pkg::REG_SIM_LIMIT,
                    (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF :
                    (r == 2) ? $urandom_range(0, 65535) : $urandom_range(1, 6));
         end
         settings_used++;
         sender_calm = ($urandom_range(0, 4) == 0);
         receiver_calm <= ($urandom_range(0, 4) == 0);
         steady_pct = $urandom_range(40, 90);
         for (k = 0; k < NUM_CLUSTERS; k++) begin
            if ($urandom_range(0, 2) == 0) begin
               track_gen[k] = ($urandom_range(0, 19) == 0) ?
                              16'($urandom_range(0, 65535)) : 16'd0;
               track_best[k] = fresh_value();
            end
         end
         // fewer clusters per phase lets runs get past the warm-up generations
         span = $urandom_range(1, NUM_CLUSTERS);
         phase_items = $urandom_range(40, 110);
         repeat (phase_items)
            send_next_generation(3'($urandom_range(0, span - 1)), steady_pct);
      end
      sender_calm = 1'b0;
      receiver_calm <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= hold_len;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!receiver_calm && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_stop === 1'b1) stops_seen++;
         if (pending_stops.size() == 0) begin
            report_mismatch("stop flag beat with no report outstanding");
         end else begin
            due_now = pending_stops.pop_front();
            if (rsp_stop !== due_now.stop)
               report_mismatch($sformatf("cluster %0d generation %0d: stop %b, expected %b",
                                         due_now.cluster, due_now.gen, rsp_stop, due_now.stop));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat for %0d cycles, %0d flags outstanding",
                  IDLE_LIMIT, pending_stops.size());
         $display("tb_convergence_stop_checker: FAIL");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < NUM_CLUSTERS; k++) begin
         prior_best[k] = '0;
         flat_run[k] = '0;
         value_acc[k] = '0;
         square_acc[k] = '0;
         level[k] = '0;
         track_gen[k] = '0;
         track_best[k] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_register_readback();
      test_doublebox_edges();
      test_similarity_edges();
      test_generation_limit();
      test_output_backpressure();
      test_random_campaign();
      wait_results_done(TAIL_CYCLES);
      $display("checked %0d reports, %0d stop flags (%0d set) over %0d random settings",
               reports_sent, results_seen, stops_seen, settings_used);
      $display("reports by rule: similarity %0d, doublebox %0d, limit %0d, unused code %0d",
               mode_reports[csc_pkg::MODE_SIMILARITY], mode_reports[csc_pkg::MODE_DOUBLEBOX],
               mode_reports[csc_pkg::MODE_GENERATIONS], mode_reports[MODE_UNUSED]);
      if (fail_count == 0)
         $display("tb_convergence_stop_checker: PASS");
      else
         $display("tb_convergence_stop_checker: FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/csc_pkg.sv
rtl/core/convergence_stop_checker.sv
bench/tb_convergence_stop_checker.sv
